// ----- design/srec_pkg.sv -----
// Shared types, codes and the hex digit decoder for the S-record line checker.
// Used by srec_line_checker_unit and its bound checker; no dependencies.
`default_nettype none

package srec_pkg;

    localparam int DATA_W = 72;  // 71 payload bits padded to whole bytes

    // parse phase codes
    localparam logic [2:0] PH_START = 3'd0;
    localparam logic [2:0] PH_TYPE  = 3'd1;
    localparam logic [2:0] PH_COUNT = 3'd2;
    localparam logic [2:0] PH_ADDR  = 3'd3;
    localparam logic [2:0] PH_DATA  = 3'd4;
    localparam logic [2:0] PH_CSUM  = 3'd5;
    localparam logic [2:0] PH_DONE  = 3'd6;

    // line status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_CSUM    = 3'd1;
    localparam logic [2:0] ST_SYNTAX  = 3'd2;
    localparam logic [2:0] ST_COUNT   = 3'd3;
    localparam logic [2:0] ST_TRUNC   = 3'd4;
    localparam logic [2:0] ST_NONDATA = 3'd5;

    // result kinds
    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // input functions
    localparam logic FUNC_CHAR = 1'b0;
    localparam logic FUNC_EOL  = 1'b1;

    localparam logic [7:0] CH_S    = 8'h53;
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_9    = 8'h39;
    localparam logic [7:0] CH_A    = 8'h41;
    localparam logic [7:0] CH_F    = 8'h46;
    localparam logic [7:0] SUM_INV = 8'hFF;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } nibble_t;

    function automatic nibble_t nibble_of(input logic [7:0] c);
        nibble_t n;
        logic [7:0] d;
        n = '0;
        d = '0;
        if (c >= CH_0 && c <= CH_9) begin
            d = c - CH_0;
            n.valid = 1'b1;
            n.value = d[3:0];
        end else if (c >= CH_A && c <= CH_F) begin
            d = c - CH_A + 8'd10;
            n.valid = 1'b1;
            n.value = d[3:0];
        end
        return n;
    endfunction

endpackage

`default_nettype wire

// ----- design/srec_line_checker_unit.sv -----
// S-record line checker: parses one text line per run of character transfers.
// Depends on srec_pkg (codes, nibble decoder).
//
// Usage:
//   Input channel (s_*): one transfer per character with s_tuser = 0 and the
//   ASCII code in s_tdata; a transfer with s_tuser = 1 ends the line.
//   Result channel (m_*): a data-byte result (m_tuser = 0) follows the
//   character that completes each data byte; the end-of-line transfer
//   always yields one status result (m_tuser = 1). Other characters yield
//   nothing.
//   A result is registered: it is on m_* in the cycle after the causing
//   transfer when the output register is free; a stalled receiver delays it further.
//   Throughput: one character per cycle while s_tready is high; the parse state
//   updates in the accepting cycle, and the result lands in an output register.
//   A one-entry skid register behind the output register keeps s_tready
//   high for a single result during a result stall; s_tready drops only while the skid
//   entry is occupied.
//   Reset (aresetn low, synchronous): parser returns to expecting 'S',
//   all sums and fields clear, both result registers empty.
//   After an end-of-line transfer the parser is back in its reset state.
`default_nettype none

module srec_line_checker_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] ch
    input  wire logic        s_tuser,   // [0] func
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [7:0] data_byte, [15:8] data_index, [18:16] status, [22:19] record_type,
    // [30:23] byte_count, [62:31] record_address, [70:63] received_checksum,
    // [71] zero
    output logic [srec_pkg::DATA_W-1:0] m_tdata,
    output logic             m_tuser    // [0] kind
);

    // parse state
    logic [2:0]  phase_reg,       phase_next;
    logic [3:0]  type_reg,        type_next;
    logic [2:0]  addr_bytes_reg,  addr_bytes_next;
    logic [7:0]  count_reg,       count_next;
    logic [31:0] address_reg,     address_next;
    logic [8:0]  digits_left_reg, digits_left_next;
    logic [3:0]  high_nibble_reg, high_nibble_next;
    logic [7:0]  sum_reg,         sum_next;
    logic [7:0]  byte_index_reg,  byte_index_next;
    logic [7:0]  checksum_reg,    checksum_next;
    logic [2:0]  error_reg,       error_next;

    // result path
    logic                        out_valid_reg;
    logic [srec_pkg::DATA_W-1:0] out_data_reg;
    logic                        out_kind_reg;
    logic                        skid_valid_reg;
    logic [srec_pkg::DATA_W-1:0] skid_data_reg;
    logic                        skid_kind_reg;

    logic                        accept;
    logic                        out_free;
    logic                        res_fire;
    logic                        res_kind;
    logic [7:0]                  res_byte;
    logic [7:0]                  res_index;
    logic [2:0]                  res_status;
    logic [7:0]                  res_csum;
    logic [srec_pkg::DATA_W-1:0] res_data;

    srec_pkg::nibble_t nib;
    logic        whole;
    logic [7:0]  byte_val;
    logic [8:0]  dl_dec;
    logic [7:0]  data_bytes;

    assign s_tready = ~skid_valid_reg;
    assign accept   = s_tvalid & s_tready;
    assign out_free = ~out_valid_reg | m_tready;

    assign nib        = srec_pkg::nibble_of(s_tdata);
    assign whole      = digits_left_reg[0];
    assign byte_val   = {high_nibble_reg, nib.value};
    assign dl_dec     = digits_left_reg - 9'd1;
    assign data_bytes = count_reg - 8'd1 - {5'd0, addr_bytes_reg};

    always_comb begin
        phase_next       = phase_reg;
        type_next        = type_reg;
        addr_bytes_next  = addr_bytes_reg;
        count_next       = count_reg;
        address_next     = address_reg;
        digits_left_next = digits_left_reg;
        high_nibble_next = high_nibble_reg;
        sum_next         = sum_reg;
        byte_index_next  = byte_index_reg;
        checksum_next    = checksum_reg;
        error_next       = error_reg;
        res_fire         = 1'b0;
        res_kind         = srec_pkg::KIND_DATA;
        res_byte         = '0;
        res_index        = '0;
        res_status       = srec_pkg::ST_OK;
        res_csum         = '0;

        if (accept) begin
            if (s_tuser == srec_pkg::FUNC_EOL) begin
                res_fire = 1'b1;
                res_kind = srec_pkg::KIND_STATUS;
                res_csum = checksum_reg;  // stays zero unless the checksum completed
                if (error_reg != srec_pkg::ST_OK)
                    res_status = error_reg;
                else if (phase_reg != srec_pkg::PH_DONE)
                    res_status = srec_pkg::ST_TRUNC;
                else if ((sum_reg ^ srec_pkg::SUM_INV) != checksum_reg)
                    res_status = srec_pkg::ST_CSUM;
                else if (type_reg != 4'd1 && type_reg != 4'd2 && type_reg != 4'd3)
                    res_status = srec_pkg::ST_NONDATA;
                phase_next       = srec_pkg::PH_START;
                type_next        = '0;
                addr_bytes_next  = '0;
                count_next       = '0;
                address_next     = '0;
                digits_left_next = '0;
                high_nibble_next = '0;
                sum_next         = '0;
                byte_index_next  = '0;
                checksum_next    = '0;
                error_next       = srec_pkg::ST_OK;
            end else if (error_reg == srec_pkg::ST_OK && phase_reg != srec_pkg::PH_DONE) begin
                if (phase_reg == srec_pkg::PH_START) begin
                    if (s_tdata == srec_pkg::CH_S)
                        phase_next = srec_pkg::PH_TYPE;
                    else
                        error_next = srec_pkg::ST_SYNTAX;
                end else if (phase_reg == srec_pkg::PH_TYPE) begin
                    if (!nib.valid || nib.value == 4'd0 || nib.value == 4'd4
                            || nib.value > 4'd9) begin
                        error_next = srec_pkg::ST_SYNTAX;
                    end else begin
                        if (nib.value == 4'd1 || nib.value == 4'd5 || nib.value == 4'd9)
                            addr_bytes_next = 3'd2;
                        else if (nib.value == 4'd3 || nib.value == 4'd7)
                            addr_bytes_next = 3'd4;
                        else
                            addr_bytes_next = 3'd3;
                        type_next        = nib.value;
                        phase_next       = srec_pkg::PH_COUNT;
                        digits_left_next = 9'd2;
                    end
                end else if (!nib.valid) begin
                    error_next = (phase_reg == srec_pkg::PH_DATA) ? srec_pkg::ST_COUNT
                                                                  : srec_pkg::ST_SYNTAX;
                end else begin
                    if (!whole)
                        high_nibble_next = nib.value;
                    if (phase_reg == srec_pkg::PH_ADDR)
                        address_next = {address_reg[27:0], nib.value};
                    digits_left_next = dl_dec;
                    if (whole) begin
                        case (phase_reg)
                            srec_pkg::PH_COUNT: begin
                                count_next = byte_val;
                                sum_next   = sum_reg + byte_val;
                                if (byte_val < {5'd0, addr_bytes_reg} + 8'd1) begin
                                    error_next = srec_pkg::ST_COUNT;
                                end else begin
                                    phase_next       = srec_pkg::PH_ADDR;
                                    digits_left_next = {5'd0, addr_bytes_reg, 1'b0};
                                end
                            end
                            srec_pkg::PH_ADDR: begin
                                sum_next = sum_reg + byte_val;
                                if (dl_dec == 9'd0) begin
                                    // count minus address bytes minus checksum byte
                                    if (data_bytes == 8'd0) begin
                                        phase_next       = srec_pkg::PH_CSUM;
                                        digits_left_next = 9'd2;
                                    end else begin
                                        phase_next       = srec_pkg::PH_DATA;
                                        digits_left_next = {data_bytes, 1'b0};
                                    end
                                end
                            end
                            srec_pkg::PH_DATA: begin
                                sum_next        = sum_reg + byte_val;
                                byte_index_next = byte_index_reg + 8'd1;
                                if (dl_dec == 9'd0) begin
                                    phase_next       = srec_pkg::PH_CSUM;
                                    digits_left_next = 9'd2;
                                end
                                res_fire  = 1'b1;
                                res_byte  = byte_val;
                                res_index = byte_index_reg;
                            end
                            srec_pkg::PH_CSUM: begin
                                checksum_next = byte_val;
                                phase_next    = srec_pkg::PH_DONE;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end
        end
    end

    assign res_data = {1'b0, res_csum, address_reg, count_reg, type_reg,
                       res_status, res_index, res_byte};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= srec_pkg::PH_START;
            type_reg        <= '0;
            addr_bytes_reg  <= '0;
            count_reg       <= '0;
            address_reg     <= '0;
            digits_left_reg <= '0;
            high_nibble_reg <= '0;
            sum_reg         <= '0;
            byte_index_reg  <= '0;
            checksum_reg    <= '0;
            error_reg       <= srec_pkg::ST_OK;
            out_valid_reg   <= 1'b0;
            skid_valid_reg  <= 1'b0;
        end else begin
            phase_reg       <= phase_next;
            type_reg        <= type_next;
            addr_bytes_reg  <= addr_bytes_next;
            count_reg       <= count_next;
            address_reg     <= address_next;
            digits_left_reg <= digits_left_next;
            high_nibble_reg <= high_nibble_next;
            sum_reg         <= sum_next;
            byte_index_reg  <= byte_index_next;
            checksum_reg    <= checksum_next;
            error_reg       <= error_next;
            if (out_free) begin
                if (skid_valid_reg) begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= res_fire;
                end else begin
                    out_valid_reg  <= res_fire;
                end
            end else if (res_fire) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (skid_valid_reg) begin
                out_data_reg <= skid_data_reg;
                out_kind_reg <= skid_kind_reg;
                if (res_fire) begin
                    skid_data_reg <= res_data;
                    skid_kind_reg <= res_kind;
                end
            end else if (res_fire) begin
                out_data_reg <= res_data;
                out_kind_reg <= res_kind;
            end
        end else if (res_fire) begin
            skid_data_reg <= res_data;
            skid_kind_reg <= res_kind;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;

endmodule

`default_nettype wire

// ----- design/srec_line_checker_checker.sv -----
// Port-level assertions for srec_line_checker_unit, bound into srec_line_checker_unit.
// Depends on srec_pkg for status and kind codes.
`default_nettype none

module srec_line_checker_checker (
    input wire logic                        aclk,
    input wire logic                        aresetn,
    input wire logic                        m_tvalid,
    input wire logic                        m_tready,
    input wire logic [srec_pkg::DATA_W-1:0] m_tdata,
    input wire logic                        m_tuser
);

    // data results carry no status and no checksum
    a_data_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == srec_pkg::KIND_DATA) |->
            (m_tdata[18:16] == srec_pkg::ST_OK && m_tdata[70:63] == 8'd0))
        else $error("data result with status or checksum set");

    // an ok line must be a data record type
    a_ok_type: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == srec_pkg::KIND_STATUS && m_tdata[18:16] == srec_pkg::ST_OK)
            |-> (m_tdata[22:19] == 4'd1 || m_tdata[22:19] == 4'd2
                 || m_tdata[22:19] == 4'd3))
        else $error("ok status on a non-data record");

    // a truncated line never reports a checksum
    a_trunc_csum: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == srec_pkg::KIND_STATUS
            && m_tdata[18:16] == srec_pkg::ST_TRUNC) |-> (m_tdata[70:63] == 8'd0))
        else $error("truncated line with a received checksum");

    // nothing left over out of reset
    a_reset_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(aresetn) |-> !m_tvalid)
        else $error("result valid right after reset");

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule

bind srec_line_checker_unit srec_line_checker_checker u_srec_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for srec_line_checker_unit: S-record lines go in one
// character per transfer; data bytes and line status are checked against a local parser.
// Depends on srec_pkg and srec_line_checker_unit.

module tb;

    localparam int WATCHDOG_CYCLES = 2000;
    localparam int TOTAL_ITEMS     = 800;
    localparam logic [7:0] LC_S    = 8'h73;  // lower-case 's'
    localparam logic [7:0] LC_A    = 8'h61;  // lower-case 'a'
    localparam logic [7:0] CH_G    = 8'h47;
    localparam logic [7:0] CH_COLON = 8'h3A;

    typedef struct packed {
        logic        kind;
        logic [7:0]  dbyte;
        logic [7:0]  idx;
        logic [2:0]  status;
        logic [3:0]  rtype;
        logic [7:0]  count;
        logic [31:0] addr;
        logic [7:0]  rx_sum;
    } line_result_t;

    typedef struct {
        logic       func;
        logic [7:0] ch;
        int         gap;
        bit         hold;
    } char_item_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [7:0] s_tdata = 8'h00;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [srec_pkg::DATA_W-1:0] m_tdata;
    logic m_tuser;

    srec_line_checker_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #2 aclk = ~aclk;

    char_item_t   char_q[$];
    line_result_t parsed_q[$];
    logic [7:0]   line_chars[$];
    int  sent_items = 0;
    bit  steady_tx = 1'b0;
    int  mismatches = 0;
    int  idle_cycles = 0;
    bit  wd_expired = 1'b0;
    bit  results_drained = 1'b1;

    // parser state
    logic [2:0]  ps_phase;
    logic [3:0]  ps_type;
    logic [7:0]  ps_count;
    logic [31:0] ps_addr;
    logic [8:0]  ps_left;
    logic [3:0]  ps_hi;
    logic [7:0]  ps_sum;
    logic [7:0]  ps_idx;
    logic [7:0]  ps_csum;
    logic [2:0]  ps_err;
    int          ps_adig;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // {valid, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        if (c >= srec_pkg::CH_0 && c <= srec_pkg::CH_9)
            return {1'b1, 4'(c - srec_pkg::CH_0)};
        if (c >= srec_pkg::CH_A && c <= srec_pkg::CH_F)
            return {1'b1, 4'(c - srec_pkg::CH_A + 8'd10)};
        return 5'd0;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        return (n < 4'd10) ? srec_pkg::CH_0 + n : srec_pkg::CH_A + n - 8'd10;
    endfunction

    function automatic int addr_digits(input logic [3:0] t);
        case (t)
            4'd1, 4'd5, 4'd9: return 4;
            4'd2, 4'd6, 4'd8: return 6;
            4'd3, 4'd7:       return 8;
            default:          return 0;
        endcase
    endfunction

    function automatic string fmt_result(input line_result_t r);
        return $sformatf("kind=%0d byte=%h idx=%0d status=%0d type=%0d count=%h addr=%h csum=%h",
                         r.kind, r.dbyte, r.idx, r.status, r.rtype, r.count, r.addr, r.rx_sum);
    endfunction

    task automatic clear_parser();
        ps_phase = srec_pkg::PH_START;
        ps_type  = '0;
        ps_count = '0;
        ps_addr  = '0;
        ps_left  = '0;
        ps_hi    = '0;
        ps_sum   = '0;
        ps_idx   = '0;
        ps_csum  = '0;
        ps_err   = srec_pkg::ST_OK;
        ps_adig  = 0;
    endtask

    task automatic parse_step(input logic func, input logic [7:0] c);
        line_result_t r;
        logic [4:0] hd;
        logic [7:0] b;
        logic whole;
        r = '0;
        hd = hex_digit(c);
        if (func == srec_pkg::FUNC_EOL) begin
            r.kind = srec_pkg::KIND_STATUS;
            if (ps_err != srec_pkg::ST_OK)
                r.status = ps_err;
            else if (ps_phase != srec_pkg::PH_DONE)
                r.status = srec_pkg::ST_TRUNC;
            else if ((~ps_sum) != ps_csum)
                r.status = srec_pkg::ST_CSUM;
            else if (ps_type != 4'd1 && ps_type != 4'd2 && ps_type != 4'd3)
                r.status = srec_pkg::ST_NONDATA;
            else
                r.status = srec_pkg::ST_OK;
            r.rtype  = ps_type;
            r.count  = ps_count;
            r.addr   = ps_addr;
            r.rx_sum = (ps_phase == srec_pkg::PH_DONE) ? ps_csum : 8'h00;
            parsed_q.push_back(r);
            clear_parser();
        end else if (ps_err != srec_pkg::ST_OK || ps_phase == srec_pkg::PH_DONE) begin
            // first error holds; anything after the checksum is dropped
        end else if (ps_phase == srec_pkg::PH_START) begin
            if (c == srec_pkg::CH_S)
                ps_phase = srec_pkg::PH_TYPE;
            else
                ps_err = srec_pkg::ST_SYNTAX;
        end else if (ps_phase == srec_pkg::PH_TYPE) begin
            if (!hd[4] || addr_digits(hd[3:0]) == 0) begin
                ps_err = srec_pkg::ST_SYNTAX;
            end else begin
                ps_adig  = addr_digits(hd[3:0]);
                ps_type  = hd[3:0];
                ps_phase = srec_pkg::PH_COUNT;
                ps_left  = 9'd2;
            end
        end else if (!hd[4]) begin
            ps_err = (ps_phase == srec_pkg::PH_DATA) ? srec_pkg::ST_COUNT
                                                     : srec_pkg::ST_SYNTAX;
        end else begin
            whole = ps_left[0];
            if (!whole)
                ps_hi = hd[3:0];
            if (ps_phase == srec_pkg::PH_ADDR)
                ps_addr = {ps_addr[27:0], hd[3:0]};
            ps_left = ps_left - 9'd1;
            if (whole) begin
                b = {ps_hi, hd[3:0]};
                case (ps_phase)
                    srec_pkg::PH_COUNT: begin
                        ps_count = b;
                        ps_sum = ps_sum + b;
                        if (int'(b) < ps_adig / 2 + 1) begin
                            ps_err = srec_pkg::ST_COUNT;
                        end else begin
                            ps_phase = srec_pkg::PH_ADDR;
                            ps_left = 9'(ps_adig);
                        end
                    end
                    srec_pkg::PH_ADDR: begin
                        ps_sum = ps_sum + b;
                        if (ps_left == 9'd0) begin
                            ps_left = 9'((int'(ps_count) - 1 - ps_adig / 2) * 2);
                            if (ps_left == 9'd0) begin
                                ps_phase = srec_pkg::PH_CSUM;
                                ps_left = 9'd2;
                            end else begin
                                ps_phase = srec_pkg::PH_DATA;
                            end
                        end
                    end
                    srec_pkg::PH_DATA: begin
                        r.kind   = srec_pkg::KIND_DATA;
                        r.dbyte  = b;
                        r.idx    = ps_idx;
                        r.status = srec_pkg::ST_OK;
                        ps_sum = ps_sum + b;
                        ps_idx = ps_idx + 8'd1;
                        if (ps_left == 9'd0) begin
                            ps_phase = srec_pkg::PH_CSUM;
                            ps_left = 9'd2;
                        end
                        r.rtype = ps_type;
                        r.count = ps_count;
                        r.addr  = ps_addr;
                        parsed_q.push_back(r);
                    end
                    default: begin
                        ps_csum = b;
                        ps_phase = srec_pkg::PH_DONE;
                    end
                endcase
            end
        end
    endtask

    task automatic check_result(input logic kind, input logic [srec_pkg::DATA_W-1:0] d);
        line_result_t got, want;
        bit bad;
        got.kind   = kind;
        got.dbyte  = d[7:0];
        got.idx    = d[15:8];
        got.status = d[18:16];
        got.rtype  = d[22:19];
        got.count  = d[30:23];
        got.addr   = d[62:31];
        got.rx_sum = d[70:63];
        if (parsed_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: %s", fmt_result(got));
        end else begin
            want = parsed_q.pop_front();
            bad = (got.kind !== want.kind) || (got.dbyte !== want.dbyte) ||
                  (got.idx !== want.idx) || (got.status !== want.status) ||
                  (got.rtype !== want.rtype) || (got.count !== want.count) ||
                  (got.addr !== want.addr) || (got.rx_sum !== want.rx_sum) ||
                  (d[71] !== 1'b0);
            if (bad) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch at %0t: expected %s", $realtime, fmt_result(want));
                    $display("                 got      %s pad=%b", fmt_result(got), d[71]);
                end
            end
        end
    endtask

    task automatic add_item(input logic func, input logic [7:0] c, input bit hold);
        char_item_t it;
        it.func = func;
        it.ch   = c;
        it.hold = hold;
        it.gap  = steady_tx ? 0 : pick_gap();
        char_q.push_back(it);
        sent_items++;
    endtask

    task automatic push_byte(input logic [7:0] b);
        line_chars.push_back(hex_char(b[7:4]));
        line_chars.push_back(hex_char(b[3:0]));
    endtask

    // well-formed record; sum_flip != 0 spoils the checksum
    task automatic build_record(input logic [3:0] rtype, input int nbytes,
                                input logic [31:0] addr, input logic [7:0] sum_flip);
        int abytes;
        logic [7:0] cnt, sum, b;
        abytes = addr_digits(rtype) / 2;
        cnt = 8'(abytes + nbytes + 1);
        line_chars.delete();
        line_chars.push_back(srec_pkg::CH_S);
        line_chars.push_back(hex_char(rtype));
        push_byte(cnt);
        sum = cnt;
        for (int i = abytes - 1; i >= 0; i--) begin
            b = addr[8*i +: 8];
            push_byte(b);
            sum = sum + b;
        end
        for (int i = 0; i < nbytes; i++) begin
            b = 8'($urandom);
            push_byte(b);
            sum = sum + b;
        end
        push_byte((~sum) ^ sum_flip);
    endtask

    task automatic send_line(input bit hold);
        for (int i = 0; i < line_chars.size(); i++)
            add_item(srec_pkg::FUNC_CHAR, line_chars[i], hold && i == 0);
        add_item(srec_pkg::FUNC_EOL, 8'($urandom), hold && line_chars.size() == 0);
    endtask

    // character source
    always @(posedge aclk) begin : drive_chars
        char_item_t it;
        int gap_left;
        bit hold_armed;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            gap_left = 0;
            hold_armed = 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (gap_left != 0) begin
                s_tvalid <= 1'b0;
                gap_left--;
            end else if (char_q.size() == 0) begin
                s_tvalid <= 1'b0;
            end else if (char_q[0].hold && !(hold_armed && results_drained)) begin
                // stay quiet until every pending result has drained
                s_tvalid <= 1'b0;
                hold_armed = 1'b1;
            end else begin
                it = char_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= it.ch;
                s_tuser  <= it.func;
                gap_left = it.gap;
                hold_armed = 1'b0;
            end
        end
    end

    // result sink backpressure
    always @(posedge aclk) begin : drive_ready
        int stall_left;
        int g;
        int rx_cycle;
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left = 0;
            rx_cycle = 0;
        end else begin
            rx_cycle++;
            if (stall_left != 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                // one stretch in every four runs without stalls
                g = (rx_cycle % 512 >= 384) ? 0 : pick_gap();
                m_tready <= (g == 0);
                stall_left = (g == 0) ? 0 : g - 1;
            end
        end
    end

    // result checking and prediction
    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_parser();
            results_drained <= 1'b1;
            idle_cycles <= 0;
        end else begin
            if (m_tvalid && m_tready)
                check_result(m_tuser, m_tdata);
            if (s_tvalid && s_tready)
                parse_step(s_tuser, s_tdata);
            results_drained <= (parsed_q.size() == 0);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else if (idle_cycles >= WATCHDOG_CYCLES)
                wd_expired <= 1'b1;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [7:0] bad_types[4];
        int r, k, n;
        logic [3:0] t;
        bad_types = '{srec_pkg::CH_0, srec_pkg::CH_0 + 8'd4, srec_pkg::CH_A, 8'hFF};

        // directed lines
        line_chars.delete();
        send_line(1'b0);                                  // empty line
        line_chars = {8'h00};
        send_line(1'b0);                                  // bad start
        line_chars = {LC_S, srec_pkg::CH_S, srec_pkg::CH_0 + 8'd1, srec_pkg::CH_0,
                      srec_pkg::CH_0};
        send_line(1'b0);                                  // error holds over later text
        for (int i = 0; i < 4; i++) begin
            line_chars = {srec_pkg::CH_S, bad_types[i], srec_pkg::CH_0, srec_pkg::CH_0};
            send_line(1'b0);                              // bad type digit
        end
        build_record(4'd1, 0, 32'h0, 8'h00);
        line_chars[3] = srec_pkg::CH_0 + 8'd2;            // count below address + 1
        send_line(1'b0);
        build_record(4'd1, 0, 32'h0, 8'h00);
        send_line(1'b1);                                  // minimal record, after a full drain
        build_record(4'd3, 2, 32'hFFFF_FFFF, 8'h00);
        send_line(1'b0);
        build_record(4'd2, 3, 32'h0, 8'h01);
        send_line(1'b0);                                  // checksum mismatch
        for (int i = 5; i <= 9; i++) begin
            build_record(4'(i), i % 3, $urandom, 8'h00);
            send_line(1'b0);                              // non-data types
        end
        build_record(4'd7, 1, $urandom, 8'h80);
        send_line(1'b0);                                  // checksum beats non-data
        build_record(4'd1, 2, $urandom, 8'h00);
        line_chars[2] = LC_A;
        send_line(1'b0);                                  // bad digit in count
        build_record(4'd1, 2, $urandom, 8'h00);
        line_chars[5] = LC_A;
        send_line(1'b0);                                  // bad digit in address
        build_record(4'd1, 3, $urandom, 8'h00);
        line_chars[10] = CH_G;
        send_line(1'b0);                                  // bad digit in data, after one byte
        build_record(4'd1, 1, $urandom, 8'h00);
        line_chars[line_chars.size() - 2] = CH_COLON;
        send_line(1'b0);                                  // bad digit in checksum
        build_record(4'd2, 3, $urandom, 8'h00);
        void'(line_chars.pop_back());
        send_line(1'b0);                                  // checksum cut short
        line_chars = {srec_pkg::CH_S};
        send_line(1'b0);
        build_record(4'd1, 1, $urandom, 8'h00);
        line_chars = {line_chars, srec_pkg::CH_S, 8'hFF, LC_A, srec_pkg::CH_0};
        send_line(1'b0);                                  // trailing characters
        build_record(4'd1, 128, 32'hFFFF, 8'h00);
        send_line(1'b0);                                  // digit count needs its top bit

        // random lines, mostly well formed
        while (sent_items < TOTAL_ITEMS) begin
            if ($urandom_range(0, 9) == 0)
                steady_tx = !steady_tx;
            t = ($urandom_range(0, 99) < 70) ? 4'($urandom_range(1, 3))
                                              : 4'($urandom_range(5, 9));
            if (t == 4'd4)
                t = 4'd5;
            n = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 8) : $urandom_range(9, 40);
            build_record(t, n, $urandom, ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'h00);
            r = $urandom_range(0, 99);
            k = $urandom_range(0, line_chars.size() - 1);
            if (r < 60) begin
            end else if (r < 70) begin
                line_chars[k] = 8'($urandom);
            end else if (r < 78) begin
                while (line_chars.size() > k)
                    void'(line_chars.pop_back());
            end else if (r < 85) begin
                repeat ($urandom_range(1, 4))
                    line_chars.push_back(8'($urandom));
            end else if (r < 90) begin
                line_chars.delete(k);
                if (line_chars.size() > 2)
                    line_chars.delete(line_chars.size() / 2);
            end else if (r < 95) begin
                line_chars.delete();
                repeat ($urandom_range(1, 6))
                    line_chars.push_back(8'($urandom));
                if ($urandom_range(0, 1) == 1)
                    line_chars[0] = srec_pkg::CH_S;
            end else begin
                line_chars = {srec_pkg::CH_S, 8'($urandom)};
                repeat ($urandom_range(0, 6))
                    line_chars.push_back(hex_char(4'($urandom)));
            end
            send_line($urandom_range(0, 99) < 3);
        end

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        @(negedge aclk);
        while (!wd_expired && (char_q.size() != 0 || s_tvalid || parsed_q.size() != 0))
            @(negedge aclk);
        if (!wd_expired)
            repeat (20) @(negedge aclk);
        if (!wd_expired && mismatches == 0 && parsed_q.size() == 0)
            $display("srec_line_checker_unit verification clean");
        else
            $display("srec_line_checker_unit verification failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/srec_pkg.sv
design/srec_line_checker_unit.sv
design/srec_line_checker_checker.sv
tb/tb.sv
